@@ design/wdr_pkg.sv @@
// Package for the Weyl dominant chamber reflection block.
// Holds the widths, codes, state encoding and the structs that the modules share.
// Depends on nothing.
`default_nettype none
package wdr_pkg;

   localparam int NCOORD          = 8;
   localparam int RANK            = 8;
   localparam int MAX_REFLECTIONS = 128;

   localparam int COORD_W  = 20;
   localparam int ENTRY_W  = 3;
   localparam int ROW_W    = NCOORD * ENTRY_W;
   localparam int PROD_W   = COORD_W + ENTRY_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int IDX_W    = $clog2(NCOORD);
   localparam int STEP_W   = $clog2(MAX_REFLECTIONS + 1);
   localparam int CODE_W   = 2;
   localparam int REQ_W    = ((NCOORD * COORD_W + 7) / 8) * 8;
   localparam int RSP_BITS = NCOORD * COORD_W + 2 * CODE_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [CODE_W-1:0] SIGN_WALL  = 2'd0;
   localparam logic [CODE_W-1:0] SIGN_PLUS  = 2'd1;
   localparam logic [CODE_W-1:0] SIGN_MINUS = 2'd2;

   localparam logic [CODE_W-1:0] ERR_OK    = 2'd0;
   localparam logic [CODE_W-1:0] ERR_OVF   = 2'd1;
   localparam logic [CODE_W-1:0] ERR_STEPS = 2'd2;

   typedef logic [NCOORD-1:0][COORD_W-1:0] coord_vec_type;
   typedef logic [NCOORD-1:0][ROW_W-1:0]   cartan_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Position found by scanning the coordinates.
   typedef struct packed {
      logic             neg;
      logic             wall;
      logic [IDX_W-1:0] idx;
   } scan_type;

   typedef struct packed {
      logic [CODE_W-1:0] err;
      logic [CODE_W-1:0] sign;
      coord_vec_type     folded;
   } result_type;

endpackage
`default_nettype wire

@@ design/wdr_lane.sv @@
// One reflection lane: updates a single coordinate by subtracting v times a Cartan entry.
// Flags a result outside the coordinate range. Uses wdr_pkg.
`default_nettype none
module wdr_lane (
   input  wire logic signed [wdr_pkg::COORD_W-1:0] coord,
   input  wire logic signed [wdr_pkg::COORD_W-1:0] pivot,
   input  wire logic signed [wdr_pkg::ENTRY_W-1:0] entry,
   output logic [wdr_pkg::COORD_W-1:0]             next_coord,
   output logic                                    ovf
);
   import wdr_pkg::*;

   logic signed [PROD_W-1:0] prod;
   logic signed [SUM_W-1:0]  diff;

   assign prod       = pivot * entry;
   assign diff       = SUM_W'(coord) - SUM_W'(prod);
   assign next_coord = diff[COORD_W-1:0];
   // The value fits when all bits from the coordinate sign bit upward agree.
   assign ovf        = !((&diff[SUM_W-1:COORD_W-1]) || !(|diff[SUM_W-1:COORD_W-1]));

endmodule
`default_nettype wire

@@ design/wdr_merge.sv @@
// Merge stage: finds the first zero or negative active coordinate and combines
// the overflow flags of all lanes. Uses wdr_pkg.
`default_nettype none
module wdr_merge (
   input  wire wdr_pkg::coord_vec_type      coords,
   input  wire logic [wdr_pkg::NCOORD-1:0]  lane_ovf,
   output wdr_pkg::scan_type                scan,
   output logic                             any_ovf
);
   import wdr_pkg::*;

   always_comb begin
      scan = '0;
      // Walk downward so the lowest matching position is the one that stays.
      for (int k = RANK - 1; k >= 0; k--) begin
         if (coords[k][COORD_W-1] || (coords[k] == '0)) begin
            scan.neg  = coords[k][COORD_W-1];
            scan.wall = !coords[k][COORD_W-1];
            scan.idx  = IDX_W'(k);
         end
      end
   end

   assign any_ovf = |lane_ovf;

endmodule
`default_nettype wire

@@ design/wdr_core.sv @@
// Folding engine: coordinate registers, step counter, control and the lane array.
// Applies one reflection per cycle. Uses wdr_pkg, wdr_lane and wdr_merge.
`default_nettype none
module wdr_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire wdr_pkg::coord_vec_type coords_in,
   input  wire wdr_pkg::cartan_type   cartan,
   input  wire logic                  out_free,
   output logic                       idle,
   output logic                       out_load,
   output wdr_pkg::result_type        result
);
   import wdr_pkg::*;

   state_type         state_ff, state_in;
   coord_vec_type     coord_ff, coord_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [CODE_W-1:0] sign_ff, sign_in;

   coord_vec_type     lane_next;
   logic [NCOORD-1:0] lane_ovf;
   logic              lane_any_ovf;
   scan_type          scan;
   logic [COORD_W-1:0] pivot;
   logic [ROW_W-1:0]  row;
   logic              at_limit;
   logic              finish;
   logic              reflect;

   assign pivot    = coord_ff[scan.idx];
   assign row      = cartan[scan.idx];
   assign at_limit = (steps_ff == STEP_W'(MAX_REFLECTIONS));

   for (genvar k = 0; k < NCOORD; k++) begin : g_lane
      logic [ENTRY_W-1:0] entry;
      assign entry = (k < RANK) ? row[k*ENTRY_W +: ENTRY_W] : '0;
      wdr_lane u_lane (
         .coord      (coord_ff[k]),
         .pivot      (pivot),
         .entry      (entry),
         .next_coord (lane_next[k]),
         .ovf        (lane_ovf[k])
      );
   end

   wdr_merge u_merge (
      .coords   (coord_ff),
      .lane_ovf (lane_ovf),
      .scan     (scan),
      .any_ovf  (lane_any_ovf)
   );

   assign finish  = scan.wall || !scan.neg || at_limit || lane_any_ovf;
   assign reflect = (state_ff == ST_RUN) && !finish;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (start) state_in = ST_RUN;
         ST_RUN:  if (finish && out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idle     = (state_ff == ST_IDLE);
      out_load = (state_ff == ST_RUN) && finish && out_free;
      result.folded = coord_ff;
      if (scan.wall) begin
         result.sign = SIGN_WALL;
         result.err  = ERR_OK;
      end else if (!scan.neg) begin
         result.sign = sign_ff;
         result.err  = ERR_OK;
      end else if (at_limit) begin
         result.sign = SIGN_WALL;
         result.err  = ERR_STEPS;
      end else begin
         result.sign = SIGN_WALL;
         result.err  = ERR_OVF;
      end
   end

   always_comb begin
      coord_in = coord_ff;
      steps_in = steps_ff;
      sign_in  = sign_ff;
      if (idle && start) begin
         for (int k = 0; k < NCOORD; k++) begin
            coord_in[k] = (k < RANK) ? coords_in[k] : COORD_W'(1);
         end
         steps_in = '0;
         sign_in  = SIGN_PLUS;
      end else if (reflect) begin
         coord_in = lane_next;
         steps_in = steps_ff + STEP_W'(1);
         sign_in  = (sign_ff == SIGN_PLUS) ? SIGN_MINUS : SIGN_PLUS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      coord_ff <= coord_in;
      steps_ff <= steps_in;
      sign_ff  <= sign_in;
   end

`ifndef SYNTH
   a_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (steps_ff <= STEP_W'(MAX_REFLECTIONS)))
      else $error("reflection count ran past the limit");

   a_load_in_run: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (state_ff == ST_RUN) && out_free)
      else $error("result loaded outside a run or into a full slot");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      (idle && start) |=> (state_ff == ST_RUN) && (steps_ff == '0))
      else $error("accepted item did not start a run");

   a_sign_flips: assert property (@(posedge clock) disable iff (reset)
      reflect |=> (sign_ff != $past(sign_ff)) && (steps_ff == $past(steps_ff) + STEP_W'(1)))
      else $error("reflection did not flip the sign and count a step");
`endif

endmodule
`default_nettype wire

@@ design/weyl_dominant_reflection_top.sv @@
// Each item takes at most MAX_REFLECTIONS reflections; a new item is taken only once the
// previous result has left the core, and the loop applies one reflection per cycle across
// all lanes.
// The result register lets the next item be taken while a result waits on rsp_tready.
// Reset is synchronous and active high; it clears control state and sets the Cartan rows
// to twice the identity.
`default_nettype none
module weyl_dominant_reflection_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // coord_0 .. coord_7, 20 bits each, from the lowest bit up
   input  wire logic [wdr_pkg::REQ_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // folded_0 .. folded_7 (20 bits each), sign_code (2), error_code (2), zero fill
   output logic [wdr_pkg::RSP_W-1:0]         rsp_tdata,
   input  wire logic                         csr_we,
   input  wire logic [wdr_pkg::IDX_W-1:0]    csr_index,
   input  wire logic [wdr_pkg::ROW_W-1:0]    csr_wdata
);
   import wdr_pkg::*;

   cartan_type  cartan_ff, cartan_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   logic        core_idle;
   logic        out_load;
   logic        out_free;
   result_type  core_result;

   assign req_tready = core_idle;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   wdr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && core_idle),
      .coords_in (coord_vec_type'(req_tdata[NCOORD*COORD_W-1:0])),
      .cartan    (cartan_ff),
      .out_free  (out_free),
      .idle      (core_idle),
      .out_load  (out_load),
      .result    (core_result)
   );

   always_comb begin
      cartan_in = cartan_ff;
      if (csr_we) begin
         cartan_in[csr_index] = csr_wdata;
      end
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = out_load ? core_result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NCOORD; i++) begin
            cartan_ff[i] <= ROW_W'(2) << (ENTRY_W * i);
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cartan_ff    <= cartan_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - RSP_BITS)'(0), rsp_data_ff};

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the Weyl dominant chamber reflection block.
// It folds each transferred weight in its own predictor and compares every result field.
// Depends on wdr_pkg and weyl_dominant_reflection_top.
module tb;
   import wdr_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int ITEMS_PER_MODE = 37;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_we;
   logic [IDX_W-1:0]    csr_index;
   logic [ROW_W-1:0]    csr_wdata;

   coord_vec_type       weight_q[$];
   result_type          folded_q[$];
   logic [ROW_W-1:0]    cartan_model[NCOORD];
   int                  weights_sent;
   int                  results_seen;
   int                  mismatches;
   int                  quiet_cycles;
   int                  send_idle_pct;
   int                  rsp_stall_pct;
   bit                  req_done;

   weyl_dominant_reflection_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Reflects in the first negative coordinate until none is left, a wall is met,
   // a reflection would overflow, or the reflection budget is spent.
   function automatic result_type fold_weight(coord_vec_type w);
      longint                      c[NCOORD];
      longint                      nxt[NCOORD];
      longint                      v;
      logic signed [COORD_W-1:0]   sx;
      logic signed [ENTRY_W-1:0]   e;
      logic [CODE_W-1:0]           sign;
      int                          steps;
      int                          bad;
      bit                          wall;
      bit                          ovf;
      bit                          done;
      result_type                  r;
      for (int k = 0; k < NCOORD; k++) begin
         sx = w[k];
         c[k] = (k < RANK) ? longint'(sx) : 64'sd1;
      end
      sign = SIGN_PLUS;
      r.sign = SIGN_WALL;
      r.err = ERR_OK;
      steps = 0;
      done = 1'b0;
      while (!done) begin
         bad = -1;
         wall = 1'b0;
         for (int k = 0; k < RANK && k < NCOORD; k++) begin
            if (bad < 0 && !wall) begin
               if (c[k] < 0)
                  bad = k;
               else if (c[k] == 0)
                  wall = 1'b1;
            end
         end
         if (wall) begin
            done = 1'b1;
         end else if (bad < 0) begin
            r.sign = sign;
            done = 1'b1;
         end else if (steps >= MAX_REFLECTIONS) begin
            r.err = ERR_STEPS;
            done = 1'b1;
         end else begin
            v = c[bad];
            ovf = 1'b0;
            for (int k = 0; k < NCOORD; k++) begin
               e = (bad < RANK && k < RANK) ? cartan_model[bad][ENTRY_W*k +: ENTRY_W] : '0;
               nxt[k] = c[k] - v * longint'(e);
               if (nxt[k] < -64'sd524288 || nxt[k] > 64'sd524287)
                  ovf = 1'b1;
            end
            if (ovf) begin
               r.err = ERR_OVF;
               done = 1'b1;
            end else begin
               c = nxt;
               sign = (sign == SIGN_PLUS) ? SIGN_MINUS : SIGN_PLUS;
               steps++;
            end
         end
      end
      for (int k = 0; k < NCOORD; k++)
         r.folded[k] = COORD_W'(c[k]);
      return r;
   endfunction

   function automatic void flag_field(string name, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
   endfunction

   function automatic coord_vec_type fill_weight(logic [COORD_W-1:0] v);
      return {NCOORD{v}};
   endfunction

   // Mostly small nonzero weights, which fold cleanly under a finite root system;
   // the rest mixes zeros, large values, raw bit patterns and the extremes.
   function automatic coord_vec_type random_weight();
      coord_vec_type w;
      int            mag;
      bit            tame;
      tame = ($urandom_range(99) < 70);
      for (int k = 0; k < NCOORD; k++) begin
         if (tame) begin
            mag = $urandom_range(200, 1);
            w[k] = $urandom_range(1) ? COORD_W'(-mag) : COORD_W'(mag);
         end else begin
            case ($urandom_range(9))
               0: w[k] = '0;
               1, 2: begin
                  mag = $urandom_range(40, 1);
                  w[k] = $urandom_range(1) ? COORD_W'(-mag) : COORD_W'(mag);
               end
               3, 4: begin
                  mag = $urandom_range(5000, 1);
                  w[k] = $urandom_range(1) ? COORD_W'(-mag) : COORD_W'(mag);
               end
               5, 6, 7: w[k] = COORD_W'($urandom);
               default: begin
                  case ($urandom_range(3))
                     0: w[k] = 20'h80000;
                     1: w[k] = 20'h7FFFF;
                     2: w[k] = 20'hFFFFF;
                     default: w[k] = 20'h00001;
                  endcase
               end
            endcase
         end
      end
      return w;
   endfunction

   function automatic cartan_type cartan_setting(int p);
      cartan_type r;
      int         ea[7] = '{0, 2, 3, 4, 5, 6, 1};
      int         eb[7] = '{2, 3, 4, 5, 6, 7, 3};
      r = '0;
      for (int i = 0; i < NCOORD; i++)
         r[i] = ROW_W'(2) << (ENTRY_W * i);
      case (p)
         0: begin
            // E8 Dynkin diagram
            for (int j = 0; j < 7; j++) begin
               r[ea[j]][ENTRY_W*eb[j] +: ENTRY_W] = 3'b111;
               r[eb[j]][ENTRY_W*ea[j] +: ENTRY_W] = 3'b111;
            end
         end
         1: begin
            for (int j = 0; j < NCOORD - 1; j++) begin
               r[j][ENTRY_W*(j+1) +: ENTRY_W] = 3'b111;
               r[j+1][ENTRY_W*j +: ENTRY_W] = 3'b111;
            end
         end
         2: begin
            for (int i = 0; i < NCOORD; i++)
               for (int k = 0; k < NCOORD; k++)
                  if (i != k && $urandom_range(3) == 0)
                     r[i][ENTRY_W*k +: ENTRY_W] = $urandom_range(1) ? 3'b111 : 3'b110;
         end
         3: begin
            for (int i = 0; i < NCOORD; i++)
               r[i] = ROW_W'($urandom);
         end
         4: r = '0;
         5: r = {NCOORD{24'hFFFFFF}};
         6: r = {NCOORD{24'h6DB6DB}};
         default: r = {NCOORD{24'h924924}};
      endcase
      return r;
   endfunction

   task automatic push_weight(coord_vec_type w);
      weight_q.push_back(w);
      weights_sent++;
   endtask

   task automatic wait_drained();
      while (results_seen != weights_sent)
         @(negedge clock);
   endtask

   task automatic write_rows(cartan_type rows);
      // The block holds no work once every result is back; a short pause keeps the
      // writes clear of the last transfer.
      repeat (4) @(negedge clock);
      for (int i = 0; i < NCOORD; i++) begin
         csr_we <= 1'b1;
         csr_index <= IDX_W'(i);
         csr_wdata <= rows[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Driver: a weight stays on the bus until its transfer has been seen at a rising edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_done) begin
            req_done = 1'b0;
            if (weight_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tdata <= weight_q.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Monitor: tracks the rows, predicts on each request transfer, checks each result.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      bit         moved;
      if (reset) begin
         for (int i = 0; i < NCOORD; i++)
            cartan_model[i] = ROW_W'(2) << (ENTRY_W * i);
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_we)
            cartan_model[csr_index] = csr_wdata;
         if (req_tvalid && req_tready) begin
            folded_q.push_back(fold_weight(req_tdata[NCOORD*COORD_W-1:0]));
            req_done = 1'b1;
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            results_seen++;
            got = result_type'(rsp_tdata[RSP_BITS-1:0]);
            if (folded_q.size() == 0) begin
               mismatches++;
               $display("%0t: result with none expected, actual %h", $time, got);
            end else begin
               want = folded_q.pop_front();
               for (int k = 0; k < NCOORD; k++)
                  if (got.folded[k] !== want.folded[k])
                     flag_field($sformatf("folded_%0d", k), want.folded[k], got.folded[k]);
               if (got.sign !== want.sign)
                  flag_field("sign_code", want.sign, got.sign);
               if (got.err !== want.err)
                  flag_field("error_code", want.err, got.err);
            end
         end
         if (moved || results_seen == weights_sent)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("** weyl_dominant_reflection_top: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      coord_vec_type w;
      int            send_pct[4] = '{0, 57, 0, 21};
      int            stall_pct[4] = '{0, 0, 57, 21};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_done = 1'b0;
      weights_sent = 0;
      results_seen = 0;
      mismatches = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed weights under the reset rows (twice the identity).
      push_weight(fill_weight(20'd1));
      push_weight(fill_weight(20'h7FFFF));
      push_weight(fill_weight(20'h80000));       // first reflection overflows
      push_weight(fill_weight(20'd0));           // wall at the first coordinate
      push_weight(fill_weight(20'hFFFFF));       // eight reflections
      w = fill_weight(20'd1); w[0] = 20'hFFFFD;
      push_weight(w);
      w = fill_weight(20'd1); w[7] = 20'h80001;
      push_weight(w);
      w = fill_weight(20'd1); w[1] = 20'd0; w[2] = 20'hFFFFB;
      push_weight(w);                            // zero ahead of a negative
      w = fill_weight(20'd5); w[0] = 20'hFFFFE; w[1] = 20'd0;
      push_weight(w);                            // wall met after one reflection
      w = fill_weight(20'd1); w[7] = 20'd0;
      push_weight(w);
      for (int k = 0; k < NCOORD; k++)
         w[k] = (k % 2 == 0) ? 20'h7FFFF : 20'h80001;
      push_weight(w);
      w = fill_weight(20'd1); w[0] = 20'hFFFFF; w[3] = 20'h80000;
      push_weight(w);                            // overflow after a good reflection
      w = fill_weight(20'h55555);
      push_weight(w);
      w = fill_weight(20'hAAAAA);
      push_weight(w);
      repeat (4) push_weight(random_weight());
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         write_rows(cartan_setting(p));
         for (int m = 0; m < 4; m++) begin
            send_idle_pct = send_pct[m];
            rsp_stall_pct = stall_pct[m];
            repeat (ITEMS_PER_MODE) push_weight(random_weight());
            wait_drained();
         end
      end

      repeat (20) @(negedge clock);
      if (mismatches == 0 && folded_q.size() == 0) begin
         $display("** weyl_dominant_reflection_top: PASSED **");
      end else begin
         $display("** weyl_dominant_reflection_top: FAILED **");
      end
      $finish;
   end

endmodule

@@ weyl_dominant_reflection_top.f @@
design/wdr_pkg.sv
design/wdr_lane.sv
design/wdr_merge.sv
design/wdr_core.sv
design/weyl_dominant_reflection_top.sv
verif/tb.sv
